/* rtl/core/b64e_pkg.sv */
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    PHASE_START = 2'd0,
    PHASE_ONE   = 2'd1,
    PHASE_TWO   = 2'd2,
    PHASE_SPARE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } char_item_t;

  // Characters produced by one request; last_idx selects the final one used.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            last;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = CHAR_UPPER + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CHAR_LOWER + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = CHAR_DIGIT + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

endpackage

/* rtl/core/b64e_front.sv */
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  byte_item_t byte_item,
  input  logic       q_full,
  output logic       byte_stall,
  output logic       push,
  output job_t       push_job
);

  logic [3:0] pending;
  logic [3:0] pending_next;
  phase_t     phase;
  phase_t     phase_next;

  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      phase   <= PHASE_START;
    end else if (push) begin
      pending <= pending_next;
      phase   <= phase_next;
    end
  end

  always_comb begin
    logic [7:0] b;
    b = byte_item.data_byte;
    push_job = '0;
    push_job.chars = {4{PAD_CHAR}};
    case (phase)
      PHASE_ONE: begin
        push_job.chars[0] = sextet_char({pending[1:0], b[7:4]});
        push_job.last_idx = 2'd0;
        pending_next      = b[3:0];
        phase_next        = PHASE_TWO;
      end
      PHASE_TWO: begin
        push_job.chars[0] = sextet_char({pending[3:0], b[7:6]});
        push_job.chars[1] = sextet_char(b[5:0]);
        push_job.last_idx = 2'd1;
        pending_next      = '0;
        phase_next        = PHASE_START;
      end
      default: begin
        push_job.chars[0] = sextet_char(b[7:2]);
        push_job.last_idx = 2'd0;
        pending_next      = {2'b00, b[1:0]};
        phase_next        = PHASE_ONE;
      end
    endcase

    // The final byte flushes the leftover bits and pads to a full group.
    if (byte_item.final_byte) begin
      push_job.last = 1'b1;
      case (phase_next)
        PHASE_ONE: begin
          push_job.chars[1] = sextet_char({pending_next[1:0], 4'b0000});
          push_job.last_idx = 2'd3;
        end
        PHASE_TWO: begin
          push_job.chars[1] = sextet_char({pending_next[3:0], 2'b00});
          push_job.last_idx = 2'd2;
        end
        default: begin
        end
      endcase
      pending_next = '0;
      phase_next   = PHASE_START;
    end
  end

endmodule

/* rtl/core/b64e_queue.sv */
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on write");

endmodule

/* rtl/core/b64e_back.sv */
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       pop_job,
  output logic       pop,
  input  logic       char_stall,
  output logic       char_valid,
  output char_item_t char_item
);

  job_t       job;
  logic       job_valid;
  logic [1:0] idx;
  logic       job_done;

  assign char_valid         = job_valid;
  assign char_item.out_char = job.chars[idx];
  assign char_item.out_last = job.last && (idx == job.last_idx);

  assign job_done = job_valid && !char_stall && (idx == job.last_idx);
  assign pop      = !q_empty && (!job_valid || job_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (job_done) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (job_valid && !char_stall) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

/* rtl/core/base64_stream_encoder.sv */
// A byte accepted at the byte port is written into the job queue, then popped
// into the output job register, from which its first character is driven.
// Throughput: one character per cycle while char_stall is low, so one byte per
// cycle in short bursts and three bytes per four characters on average.
// The byte port stalls only while the job queue of QUEUE_DEPTH entries is full.
// Reset clears the group position, the pending bits, the queue and the output.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       char_valid,
  input  logic       char_stall,
  output char_item_t char_item
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .byte_stall (byte_stall),
    .push       (push),
    .push_job   (push_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop_job    (pop_job),
    .pop        (pop),
    .char_stall (char_stall),
    .char_valid (char_valid),
    .char_item  (char_item)
  );

endmodule
